### hdl/wve_pkg.sv
package wve_pkg;

    // signed time difference width (two 32-bit times)
    localparam int TDW = 33;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    // largest magnitude whose product with US_PER_S fits a signed 64-bit word
    localparam logic [63:0] MAG_LIMIT = 64'd9223372036854;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] quot;
    } div_res_t;

endpackage

### hdl/wve_div.sv
module wve_div import wve_pkg::*; #(
    parameter int POS_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [POS_WIDTH:0] num,
    input  logic signed [TDW-1:0]    den,
    output div_res_t                 res
);

    localparam int MW = POS_WIDTH + 1;
    localparam int DW = MW + 20;
    localparam int UW = DW - 33;
    localparam int CW = (UW > 34) ? UW : 34;

    typedef enum logic [2:0] {D_IDLE, D_MUL, D_CHK, D_ITER, D_DONE} dstate_t;

    dstate_t       state_reg;
    logic [MW-1:0] mag_reg;
    logic [32:0]   dmag_reg;
    logic          neg_reg, nneg_reg, zden_reg, nzero_reg, big_reg;
    logic [DW-1:0] prod_reg;
    logic [32:0]   lo_reg;
    logic [33:0]   rem_reg;
    logic [32:0]   q_reg;
    logic [5:0]    cnt_reg;
    logic          ovf_reg;
    logic          done_reg;
    logic          sat_reg;
    logic signed [31:0] quot_reg;

    logic [MW-1:0] num_mag;
    logic [32:0]   den_mag;
    logic [CW-1:0] upper_w, dmag_w;
    logic [33:0]   trial;
    logic          fit;

    always_comb begin
        num_mag = num[POS_WIDTH] ? MW'(-num) : MW'(num);
        den_mag = den[TDW-1] ? 33'(-den) : 33'(den);
        upper_w = CW'(prod_reg[DW-1:33]);
        dmag_w  = CW'(dmag_reg);
        trial   = {rem_reg[32:0], lo_reg[32]};
        fit     = trial >= {1'b0, dmag_reg};
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        mag_reg   <= num_mag;
                        dmag_reg  <= den_mag;
                        nneg_reg  <= num[POS_WIDTH];
                        neg_reg   <= num[POS_WIDTH] ^ den[TDW-1];
                        zden_reg  <= (den == '0);
                        nzero_reg <= (num == '0);
                        big_reg   <= 64'(num_mag) > MAG_LIMIT;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    prod_reg  <= DW'(mag_reg) * DW'(US_PER_S);
                    state_reg <= D_CHK;
                end
                D_CHK: begin
                    ovf_reg <= 1'b0;
                    q_reg   <= '0;
                    lo_reg  <= prod_reg[32:0];
                    cnt_reg <= 6'd33;
                    if (zden_reg || big_reg) begin
                        state_reg <= D_DONE;
                    end else if (upper_w >= dmag_w) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= D_DONE;
                    end else begin
                        rem_reg   <= 34'(upper_w);
                        state_reg <= D_ITER;
                    end
                end
                D_ITER: begin
                    rem_reg <= fit ? trial - {1'b0, dmag_reg} : trial;
                    q_reg   <= {q_reg[31:0], fit};
                    lo_reg  <= {lo_reg[31:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE: begin
                    // clamp and sign the quotient
                    if (zden_reg) begin
                        sat_reg  <= 1'b1;
                        quot_reg <= nzero_reg ? '0 : (nneg_reg ? Q_MIN : Q_MAX);
                    end else if (big_reg || ovf_reg) begin
                        sat_reg  <= 1'b1;
                        quot_reg <= neg_reg ? Q_MIN : Q_MAX;
                    end else if (neg_reg) begin
                        sat_reg  <= q_reg > 33'h0_8000_0000;
                        quot_reg <= (q_reg > 33'h0_8000_0000) ? Q_MIN : 32'(-q_reg);
                    end else begin
                        sat_reg  <= q_reg > 33'h0_7fff_ffff;
                        quot_reg <= (q_reg > 33'h0_7fff_ffff) ? Q_MAX : 32'(q_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.quot = quot_reg;

endmodule

### hdl/waypoint_velocity_estimator_top.sv
// channel   ports                                   direction
// s_        valid/ready, position, time, velocity   in, one sample per transfer
// m_        valid/ready, velocity, joint, flags     out, zero to two per sample
// cfg_      valid/ready, joint count                in, always ready
//
// A sample that needs no division skips the divider and goes straight to its result
// transfers, if any. An interior sample that needs the mean runs two divisions, one
// after the other, on one shared restoring divider, then halves their sum. Receiver
// stalls hold each result in its output state until m_ready.
// Synchronous active-low reset clears control state; per-joint storage is not
// cleared. s_ready is low while a sample is in work or its results wait.
module waypoint_velocity_estimator_top import wve_pkg::*; #(
    parameter int MAX_JOINTS = 32,
    parameter int POS_WIDTH  = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_position,
    input  logic [31:0]        s_time_us,
    input  logic               s_velocity_given,
    input  logic signed [31:0] s_given_velocity,
    input  logic               s_final_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_velocity,
    output logic [4:0]         m_joint_index,
    output logic               m_saturated,
    output logic               m_run_end,
    output logic               m_trajectory_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data
);

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int PW = POS_WIDTH;
    localparam int WW = 2 * PW + 33;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GOA, S_WA, S_GOB, S_WB, S_MEAN, S_OUT1, S_OUT2, S_FINISH
    } state_t;

    state_t            state_reg;
    logic [5:0]        count_reg;
    logic [JW-1:0]     joint_reg;
    logic [1:0]        seen_reg;
    logic [31:0]       older_time_reg, middle_time_reg, cur_time_reg;
    logic signed [PW-1:0] pos_reg;
    logic              given_reg, final_reg, last_reg;
    logic [31:0]       gvel_reg;
    logic signed [PW-1:0] prev_reg, mid_reg;
    logic signed [31:0] qa_reg;
    logic              sat_reg;
    logic              m_valid_reg;
    logic signed [31:0] vel_reg;
    logic              msat_reg, end_reg, done_reg;

    logic [WW-1:0]     mem [MAX_JOINTS];
    logic [WW-1:0]     rd_reg;

    logic [PW+31:0]    pos_raw;
    logic signed [PW-1:0] rd_old, rd_mid;
    logic              rd_has;
    logic [31:0]       rd_vel;
    logic [8:0]        count_eff;
    logic              last_now, zero_now;
    logic              div_start;
    logic signed [PW:0] div_num;
    logic signed [TDW-1:0] div_den;
    div_res_t          div_res;
    logic signed [32:0] mean_sum;

    always_comb begin
        pos_raw   = {{PW{1'b0}}, s_position};
        rd_old    = rd_reg[WW-1 -: PW];
        rd_mid    = rd_reg[PW+32 -: PW];
        rd_has    = rd_reg[32];
        rd_vel    = rd_reg[31:0];
        if (count_reg == 6'd0) begin
            count_eff = 9'd1;
        end else if (9'(count_reg) > 9'(MAX_JOINTS)) begin
            count_eff = 9'(MAX_JOINTS);
        end else begin
            count_eff = 9'(count_reg);
        end
        last_now = (9'(joint_reg) + 9'd1) >= count_eff;
        zero_now = (rd_mid == rd_old) || (rd_mid < rd_old && rd_mid <= pos_reg)
                   || (rd_mid > rd_old && rd_mid >= pos_reg);
        div_start = (state_reg == S_GOA) || (state_reg == S_GOB);
        if (state_reg == S_GOA) begin
            div_num = (PW+1)'(mid_reg) - (PW+1)'(prev_reg);
            div_den = {1'b0, middle_time_reg} - {1'b0, older_time_reg};
        end else begin
            div_num = (PW+1)'(pos_reg) - (PW+1)'(mid_reg);
            div_den = {1'b0, cur_time_reg} - {1'b0, middle_time_reg};
        end
        mean_sum = 33'(qa_reg) + 33'(div_res.quot);
    end

    wve_div #(.POS_WIDTH(POS_WIDTH)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    // per-joint history, read at the current joint every cycle
    always_ff @(posedge aclk) begin
        rd_reg <= mem[joint_reg];
        if (state_reg == S_LOAD) begin
            mem[joint_reg] <= {(seen_reg != 2'd0) ? rd_mid : rd_old, pos_reg,
                               given_reg, gvel_reg};
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 6'd1;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            joint_reg       <= '0;
            seen_reg        <= 2'd0;
            older_time_reg  <= '0;
            middle_time_reg <= '0;
            cur_time_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        pos_reg   <= pos_raw[PW-1:0];
                        given_reg <= s_velocity_given;
                        gvel_reg  <= s_given_velocity;
                        final_reg <= s_final_point;
                        if (joint_reg == '0) begin
                            cur_time_reg <= s_time_us;
                        end
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    last_reg <= last_now;
                    prev_reg <= rd_old;
                    mid_reg  <= rd_mid;
                    sat_reg  <= 1'b0;
                    if (seen_reg == 2'd2) begin
                        if (rd_has || zero_now) begin
                            vel_reg     <= rd_has ? rd_vel : '0;
                            msat_reg    <= 1'b0;
                            end_reg     <= !final_reg;
                            done_reg    <= 1'b0;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT1;
                        end else begin
                            state_reg <= S_GOA;
                        end
                    end else if (seen_reg == 2'd0 || final_reg) begin
                        vel_reg     <= given_reg ? gvel_reg : '0;
                        msat_reg    <= 1'b0;
                        end_reg     <= 1'b1;
                        done_reg    <= final_reg && last_now;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT2;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_GOA: state_reg <= S_WA;
                S_WA: begin
                    if (div_res.done) begin
                        qa_reg    <= div_res.quot;
                        sat_reg   <= div_res.sat;
                        state_reg <= S_GOB;
                    end
                end
                S_GOB: state_reg <= S_WB;
                S_WB: begin
                    if (div_res.done) begin
                        state_reg <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    // halve, truncating toward zero
                    vel_reg     <= 32'((mean_sum + 33'(mean_sum[32])) >>> 1);
                    msat_reg    <= sat_reg || div_res.sat;
                    end_reg     <= !final_reg;
                    done_reg    <= 1'b0;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT1;
                end
                S_OUT1: begin
                    if (m_ready) begin
                        if (final_reg) begin
                            vel_reg   <= given_reg ? gvel_reg : '0;
                            msat_reg  <= 1'b0;
                            end_reg   <= 1'b1;
                            done_reg  <= last_reg;
                            state_reg <= S_OUT2;
                        end else begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= S_FINISH;
                        end
                    end
                end
                S_OUT2: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // advance joint and waypoint history
                    if (last_reg) begin
                        joint_reg <= '0;
                        if (final_reg) begin
                            seen_reg <= 2'd0;
                        end else begin
                            older_time_reg  <= middle_time_reg;
                            middle_time_reg <= cur_time_reg;
                            if (seen_reg != 2'd2) begin
                                seen_reg <= seen_reg + 2'd1;
                            end
                        end
                    end else begin
                        joint_reg <= joint_reg + JW'(1);
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_velocity        = vel_reg;
    assign m_joint_index     = 5'(joint_reg);
    assign m_saturated       = msat_reg;
    assign m_run_end         = end_reg;
    assign m_trajectory_done = done_reg;

`ifndef SYNTHESIS
    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("result pending while taking a sample");
    a_joint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(joint_reg) < 32'(MAX_JOINTS))
        else $error("joint counter out of range");
    a_done_has_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trajectory_done) |-> m_run_end)
        else $error("trajectory end without run end");
    a_div_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == S_WA || state_reg == S_WB))
        else $error("divider finished outside a wait state");
`endif

endmodule
